/* design/lpm_pkg.sv */
// Shared types and constants for the LIKE pattern match unit.
package lpm_pkg;

  // Default bound on stored pattern symbols.
  localparam int MaxPatternDefault = 64;

  // Operation codes carried on the request channel.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_START  = 2'd2,
    OP_TEXT   = 2'd3
  } op_t;

  // Kind of one stored pattern symbol.
  typedef enum logic [1:0] {
    KIND_LITERAL = 2'd0,
    KIND_ANYRUN  = 2'd1,
    KIND_SINGLE  = 2'd2
  } kind_t;

  // Pattern bytes with a special meaning.
  localparam logic [7:0] ChPercent    = 8'h25;
  localparam logic [7:0] ChUnderscore = 8'h5F;
  localparam logic [7:0] ChBackslash  = 8'h5C;

  // Data that one cell hands to its right neighbor every cycle.
  typedef struct packed {
    logic       go;        // a column update passes this point
    logic       start;     // update is a start-of-text pass
    logic [7:0] ch;        // text byte of the update
    logic       new_bit;   // updated column bit of the left neighbor
    logic       old_bit;   // column bit of the left neighbor before the update
  } wave_t;

  // Pattern write into one cell.
  typedef struct packed {
    logic       clr;       // drop the whole pattern
    kind_t      kind;      // kind of the symbol being written
    logic [7:0] ch;        // literal byte of the symbol
  } cell_wr_t;

endpackage

/* design/lpm_cell.sv */
// One pattern symbol with its match column bit, updated as a wave passes.
module lpm_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  lpm_pkg::cell_wr_t wr,
  input  lpm_pkg::wave_t   wave_in,
  output lpm_pkg::wave_t   wave_out
);
  import lpm_pkg::*;

  logic       valid;
  logic       col;
  kind_t      kind;
  logic [7:0] sym_char;
  logic       col_next;

  // Column rule for this symbol, from the neighbor's new and old bits.
  always_comb begin
    col_next = 1'b0;
    if (wave_in.start) begin
      col_next = wave_in.new_bit & (kind == KIND_ANYRUN);
    end else begin
      case (kind)
        KIND_ANYRUN: col_next = wave_in.new_bit | wave_in.old_bit | col;
        KIND_SINGLE: col_next = wave_in.old_bit;
        default:     col_next = (sym_char == wave_in.ch) ? wave_in.old_bit : 1'b0;
      endcase
    end
  end

  // Symbol contents, column bit and the data handed on.
  // Cells past the pattern pass the left neighbor's new bit through.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      kind     <= wr.kind;
      sym_char <= wr.ch;
    end
    wave_out.start   <= wave_in.start;
    wave_out.ch      <= wave_in.ch;
    wave_out.new_bit <= valid ? col_next : wave_in.new_bit;
    wave_out.old_bit <= col;
    if (rst) begin
      valid       <= 1'b0;
      col         <= 1'b0;
      wave_out.go <= 1'b0;
    end else begin
      wave_out.go <= wave_in.go;
      if (wr.clr) begin
        valid <= 1'b0;
        col   <= 1'b0;
      end else if (wr_en) begin
        valid <= 1'b1;
        col   <= 1'b0;
      end else if (wave_in.go && valid) begin
        col <= col_next;
      end
    end
  end

endmodule

/* design/like_pattern_match_unit.sv */
// Top level of the LIKE pattern match unit: pattern loader and cell chain.
//
//   channel   direction  handshake           payload
//   request   in         in_valid/in_stall   op, char_byte
//   result    out        out_valid/out_stall matched, pattern_overflow
//
// Clear and append requests give no result.
// Start and text requests send a wave down the row of MAX_PATTERN cells, one
// cell per cycle; the result is registered when the wave leaves the last cell,
// and no new request is taken while the wave is running.
// Reset (rst, synchronous) empties the pattern and clears the match column.
// A stalled result waits in a holding register; requests stall only while a
// wave is running or a second result is held.
module like_pattern_match_unit #(
  parameter int MAX_PATTERN = lpm_pkg::MaxPatternDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  lpm_pkg::op_t     op,
  input  logic [7:0]       char_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             matched,
  output logic             pattern_overflow
);
  import lpm_pkg::*;

  localparam int CW = $clog2(MAX_PATTERN + 1);

  logic          accept;
  logic [CW-1:0] count;
  logic          esc;
  logic          ovf;
  logic          col0;
  logic          busy;
  logic          pend;
  logic          pend_matched;
  logic          out_free;
  logic          store;
  kind_t         store_kind;
  logic          full;
  logic          wr_go;
  cell_wr_t      wr;
  wave_t         wave [MAX_PATTERN+1];

  assign accept   = in_valid && !in_stall;
  assign in_stall = busy | pend;
  assign out_free = !out_valid || !out_stall;
  assign full     = (count >= CW'(MAX_PATTERN));

  // Decode one pattern byte into a symbol, honoring a pending escape.
  always_comb begin
    store      = 1'b0;
    store_kind = KIND_LITERAL;
    if (esc) begin
      store = 1'b1;
    end else if (char_byte == ChPercent) begin
      store      = 1'b1;
      store_kind = KIND_ANYRUN;
    end else if (char_byte == ChUnderscore) begin
      store      = 1'b1;
      store_kind = KIND_SINGLE;
    end else if (char_byte != ChBackslash) begin
      store = 1'b1;
    end
  end

  assign wr_go   = accept && (op == OP_APPEND) && store && !full;
  assign wr.clr  = accept && (op == OP_CLEAR);
  assign wr.kind = store_kind;
  assign wr.ch   = (store_kind == KIND_LITERAL) ? char_byte : 8'd0;

  // Pattern bookkeeping, column bit zero, wave entry and result handling.
  always_ff @(posedge clk) begin
    if (accept) begin
      wave[0].start   <= (op == OP_START);
      wave[0].ch      <= char_byte;
      wave[0].new_bit <= (op == OP_START);
      wave[0].old_bit <= col0;
    end
    if (rst) begin
      count     <= '0;
      esc       <= 1'b0;
      ovf       <= 1'b0;
      col0      <= 1'b0;
      busy      <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      wave[0].go <= 1'b0;
    end else begin
      wave[0].go <= accept && ((op == OP_START) || (op == OP_TEXT));
      if (accept) begin
        unique case (op)
          OP_CLEAR: begin
            count <= '0;
            esc   <= 1'b0;
            ovf   <= 1'b0;
            col0  <= 1'b0;
          end
          OP_APPEND: begin
            if (esc) begin
              esc <= 1'b0;
            end else if (char_byte == ChBackslash) begin
              esc <= 1'b1;
            end
            if (store) begin
              if (full) begin
                ovf <= 1'b1;
              end else begin
                count <= count + CW'(1);
              end
            end
          end
          OP_START: begin
            col0 <= 1'b1;
            busy <= 1'b1;
          end
          OP_TEXT: begin
            col0 <= 1'b0;
            busy <= 1'b1;
          end
          default: ;
        endcase
      end

      // Wave leaves the last cell: show the result or hold it.
      if (wave[MAX_PATTERN].go) begin
        busy <= 1'b0;
        if (out_free) begin
          out_valid <= 1'b1;
        end else begin
          pend <= 1'b1;
        end
      end else if (pend && out_free) begin
        pend      <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (wave[MAX_PATTERN].go) begin
      if (out_free) begin
        matched          <= wave[MAX_PATTERN].new_bit;
        pattern_overflow <= ovf;
      end else begin
        pend_matched <= wave[MAX_PATTERN].new_bit;
      end
    end else if (pend && out_free) begin
      matched          <= pend_matched;
      pattern_overflow <= ovf;
    end
  end

  // Row of symbol cells.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    lpm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (wr_go && (count == CW'(k))),
      .wr       (wr),
      .wave_in  (wave[k]),
      .wave_out (wave[k+1])
    );
  end

endmodule
